@@ design/bipartite_check_defines.svh @@
// Assertion macros for the bipartite_check design.
// Included by files that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef BIPARTITE_CHECK_DEFINES_SVH
`define BIPARTITE_CHECK_DEFINES_SVH

// Clocked check, off while reset is asserted
`define BPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/bpc_pkg.sv @@
// Shared types and constants for the bipartite_check design.
// No dependencies; used by bpc_ctrl, bpc_datapath and bipartite_check.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int FIELD_W     = 6;
    localparam int MASK_W      = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FIELD_W-1:0] CNT_RESET = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_B,
        ST_START,
        ST_POP,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take_edge;   // accept edge, write row of first endpoint
        logic write_b;     // write row of second endpoint
        logic start;       // seed the walk at vertex 1
        logic pop;         // read top of stack
        logic fetch;       // read adjacency row of popped vertex
        logic load;        // latch neighbor row
        logic scan;        // examine one neighbor
        logic finish;      // load result, clear store
    } t_cmd;

    typedef struct packed {
        logic edge_last;
        logic n_zero;
        logic stack_empty;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

@@ design/bpc_ctrl.sv @@
// Sequencer for bipartite_check: edge loading, the coloring walk and result hand-off.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bpc_pkg::t_sts  i_sts,
    output bpc_pkg::t_cmd  o_cmd
);
    import bpc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_edge = 1'b1;
                    n_state         = ST_WR_B;
                end
            end
            ST_WR_B: begin
                o_cmd.write_b = 1'b1;
                if (!i_sts.edge_last) begin
                    n_state = ST_IDLE;
                end else if (i_sts.n_zero) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_POP;
            end
            ST_POP: begin
                if (i_sts.stack_empty) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_POP;
                end
            end
            ST_DONE: begin
                // hold until the previous result has been taken
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/bpc_datapath.sv @@
// Datapath for bipartite_check: adjacency memory with row valid bits, walk stack,
// visited and color marks, vertex count register and the result register. Uses bpc_pkg.
`timescale 1ns / 1ps

module bpc_datapath #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bpc_pkg::FIELD_W-1:0]  i_cfg_wr_data,
    input  logic [bpc_pkg::FIELD_W-1:0]  i_vertex_a,
    input  logic [bpc_pkg::FIELD_W-1:0]  i_vertex_b,
    input  logic                         i_last_edge,
    input  bpc_pkg::t_cmd                i_cmd,
    output bpc_pkg::t_sts                o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_is_bipartite,
    output logic [bpc_pkg::MASK_W-1:0]   o_color_mask,
    output logic                         o_bad_edge_seen
);
    import bpc_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = $clog2(MAX_VERTICES + 1);

    logic [FIELD_W-1:0]      r_vertex_count;
    logic [FIELD_W-1:0]      w_n;

    logic                    w_a_ok;
    logic                    w_b_ok;
    logic                    w_bad;
    logic                    w_store;
    logic [FIELD_W-1:0]      w_a_m1;
    logic [FIELD_W-1:0]      w_b_m1;
    logic [VW-1:0]           w_a_idx;
    logic [VW-1:0]           w_b_idx;

    logic [VW-1:0]           r_a_idx;
    logic [VW-1:0]           r_b_idx;
    logic                    r_store_b;
    logic                    r_last;

    logic [MAX_VERTICES-1:0] r_adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_row_rd;
    logic                    r_row_rd_vld;
    logic                    w_row_we;
    logic [VW-1:0]           w_row_addr;
    logic [VW-1:0]           w_row_bit;
    logic [MAX_VERTICES-1:0] w_row_onehot;

    logic [VW-1:0]           r_stk_mem [MAX_VERTICES];
    logic [VW-1:0]           r_stk_rd;
    logic [DW-1:0]           r_depth;
    logic [DW-1:0]           w_depth_m1;
    logic                    w_room;
    logic                    w_push;
    logic [VW-1:0]           w_push_addr;
    logic [VW-1:0]           w_push_data;

    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_colors;
    logic                    r_conflict;
    logic                    r_bad;
    logic [MAX_VERTICES-1:0] r_nb;
    logic                    r_cv;
    logic [VW-1:0]           r_i;
    logic                    w_nb_bit;
    logic                    w_vis_bit;
    logic                    w_col_bit;

    logic [MAX_VERTICES+MASK_W-1:0] w_col_wide;
    logic [MASK_W-1:0]              w_col32;

    // vertex count, clamped to the store size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_vertex_count <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if ({1'b0, r_vertex_count} > (FIELD_W + 1)'(MAX_VERTICES)) begin
            w_n = FIELD_W'(MAX_VERTICES);
        end else begin
            w_n = r_vertex_count;
        end
    end

    // edge checks on the incoming transfer
    assign w_a_ok  = (i_vertex_a != '0) && (i_vertex_a <= w_n);
    assign w_b_ok  = (i_vertex_b != '0) && (i_vertex_b <= w_n);
    assign w_bad   = !(w_a_ok && w_b_ok);
    assign w_store = !w_bad && (i_vertex_a != i_vertex_b);
    assign w_a_m1  = i_vertex_a - FIELD_W'(1);
    assign w_b_m1  = i_vertex_b - FIELD_W'(1);
    assign w_a_idx = w_a_m1[VW-1:0];
    assign w_b_idx = w_b_m1[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_edge) begin
            r_a_idx   <= w_a_idx;
            r_b_idx   <= w_b_idx;
            r_store_b <= w_store;
            r_last    <= i_last_edge;
        end
    end

    // adjacency row writes: first endpoint on accept, second in the following cycle
    always_comb begin
        w_row_we   = 1'b0;
        w_row_addr = w_a_idx;
        w_row_bit  = w_b_idx;
        if (i_cmd.take_edge) begin
            w_row_we = w_store;
        end else if (i_cmd.write_b) begin
            w_row_we   = r_store_b;
            w_row_addr = r_b_idx;
            w_row_bit  = r_a_idx;
        end
    end

    always_comb begin
        w_row_onehot            = '0;
        w_row_onehot[w_row_bit] = 1'b1;
    end

    // a row that is not valid holds stale bits: overwrite it whole on first touch
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            if (r_row_vld[w_row_addr]) begin
                r_adj_mem[w_row_addr][w_row_bit] <= 1'b1;
            end else begin
                r_adj_mem[w_row_addr] <= w_row_onehot;
            end
        end
        r_row_rd <= r_adj_mem[r_stk_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld    <= '0;
            r_row_rd_vld <= 1'b0;
        end else begin
            r_row_rd_vld <= r_row_vld[r_stk_rd];
            if (i_cmd.finish) begin
                r_row_vld <= '0;
            end else if (w_row_we) begin
                r_row_vld[w_row_addr] <= 1'b1;
            end
        end
    end

    // walk stack
    assign w_depth_m1  = r_depth - DW'(1);
    assign w_room      = r_depth < DW'(MAX_VERTICES);
    assign w_nb_bit    = r_nb[r_i];
    assign w_vis_bit   = r_visited[r_i];
    assign w_col_bit   = r_colors[r_i];
    assign w_push      = i_cmd.start || (i_cmd.scan && w_nb_bit && !w_vis_bit && w_room);
    assign w_push_addr = i_cmd.start ? '0 : r_depth[VW-1:0];
    assign w_push_data = i_cmd.start ? '0 : r_i;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stk_mem[w_push_addr] <= w_push_data;
        end
        if (i_cmd.pop) begin
            r_stk_rd <= r_stk_mem[w_depth_m1[VW-1:0]];
        end
    end

    // walk state and marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited  <= '0;
            r_colors   <= '0;
            r_conflict <= 1'b0;
            r_bad      <= 1'b0;
            r_depth    <= '0;
        end else if (i_cmd.finish) begin
            r_visited  <= '0;
            r_colors   <= '0;
            r_conflict <= 1'b0;
            r_bad      <= 1'b0;
        end else begin
            if (i_cmd.take_edge && w_bad) begin
                r_bad <= 1'b1;
            end
            if (i_cmd.start) begin
                r_visited <= MAX_VERTICES'(1);
                r_colors  <= MAX_VERTICES'(1);
                r_depth   <= DW'(1);
            end
            if (i_cmd.pop) begin
                r_depth <= w_depth_m1;
            end
            if (i_cmd.scan && w_nb_bit) begin
                if (w_vis_bit) begin
                    if (w_col_bit == r_cv) begin
                        r_conflict <= 1'b1;
                    end
                end else begin
                    r_visited[r_i] <= 1'b1;
                    r_colors[r_i]  <= !r_cv;
                    if (w_room) begin
                        r_depth <= r_depth + DW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_cv <= r_colors[r_stk_rd];
        end
        if (i_cmd.load) begin
            r_nb <= r_row_rd_vld ? r_row_rd : '0;
            r_i  <= '0;
        end else if (i_cmd.scan) begin
            r_i <= r_i + VW'(1);
        end
    end

    // result register
    assign w_col_wide = {{MASK_W{1'b0}}, r_colors};
    assign w_col32    = w_col_wide[MASK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_is_bipartite  <= !r_conflict;
            o_color_mask    <= r_conflict ? '0 : w_col32;
            o_bad_edge_seen <= r_bad;
        end
    end

    assign o_sts.edge_last   = r_last;
    assign o_sts.n_zero      = (w_n == '0);
    assign o_sts.stack_empty = (r_depth == '0);
    assign o_sts.scan_last   = ((FIELD_W + 1)'(r_i) == (FIELD_W + 1)'(w_n) - (FIELD_W + 1)'(1));
    assign o_sts.out_free    = !o_out_valid || i_out_ready;

endmodule

@@ design/bipartite_check.sv @@
// Channel    | Dir | Fields, lowest bit first
// -----------+-----+------------------------------------------------------------
// s_axis     | in  | tdata: vertex_a[5:0], vertex_b[11:6], zero pad; tlast: last_edge
// m_axis     | out | tdata: is_bipartite[0], color_mask[32:1], bad_edge_seen[33], pad
// i_cfg_wr_* | in  | vertex_count[5:0]
//
// An edge transfer writes the row of each endpoint in turn through the one-port
// adjacency memory; no new edge is taken until both rows are written. The transfer
// marked tlast adds the coloring walk, one neighbor a cycle: start, then pop, fetch,
// load and scan of n neighbors per reached vertex, then the result is loaded. Reset
// clears the row valid bits at once, so no clearing pass follows. A pending result
// does not stall edge loading; only loading a new result waits for it to be taken.
// Top level of the bipartite_check block; depends on bpc_pkg, bpc_ctrl, bpc_datapath.
`timescale 1ns / 1ps
`include "bipartite_check_defines.svh"

module bipartite_check #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bpc_pkg::FIELD_W-1:0]      i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // vertex_a, vertex_b
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // is_bipartite, color_mask,
                                                            // bad_edge_seen
);
    import bpc_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic               w_is_bipartite;
    logic [MASK_W-1:0]  w_color_mask;
    logic               w_bad_edge_seen;

    bpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_vertex_a      (s_axis_tdata[FIELD_W-1:0]),
        .i_vertex_b      (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_last_edge     (s_axis_tlast),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_is_bipartite  (w_is_bipartite),
        .o_color_mask    (w_color_mask),
        .o_bad_edge_seen (w_bad_edge_seen)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - MASK_W - 2){1'b0}},
                           w_bad_edge_seen, w_color_mask, w_is_bipartite};

    `BPC_ASSERT(a_finish_free, w_cmd.finish |-> w_sts.out_free, "result overwritten before transfer")
    `BPC_ASSERT(a_finish_valid, w_cmd.finish |=> m_axis_tvalid, "loaded result not presented")
    `BPC_ASSERT(a_pop_nonempty, w_cmd.pop |-> !w_sts.stack_empty, "pop from empty walk stack")
    `BPC_ASSERT_ALWAYS(a_walk_no_accept, (w_cmd.scan || w_cmd.pop) |-> !s_axis_tready, "input ready during walk")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for bipartite_check: edge streams in, one coloring result out.
// Depends on bpc_pkg and the bipartite_check design; predicts each result internally.
`timescale 1ns / 1ps

module testbench;

    localparam int NV     = 32;
    localparam int LIMIT  = 10_000_000;
    localparam int SETTLE = 8;

    typedef struct {
        bit        bip;
        bit [31:0] mask;
        bit        bad;
    } t_coloring;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_wr_en   = 1'b0;
    logic [bpc_pkg::FIELD_W-1:0]      i_cfg_wr_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [bpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata  = '0;  // vertex_a, vertex_b, pad
    logic                             s_axis_tlast  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [bpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;        // is_bipartite, color_mask,
                                                           // bad_edge_seen, pad

    // predictor state
    bit [31:0]  graph_rows [NV];
    bit         graph_bad;
    bit [5:0]   vertex_limit = 6'd32;
    t_coloring  pending_colorings [$];

    int src_idle  = 0;
    int sink_idle = 0;
    int errors        = 0;
    int cycle_count   = 0;
    int edges_sent    = 0;
    int graphs_sent   = 0;
    int results_seen  = 0;
    int odd_results   = 0;
    int count_writes  = 0;

    bipartite_check #(
        .MAX_VERTICES(NV)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end

    function automatic int effective_vertices();
        int n;
        n = int'(vertex_limit);
        if (n > NV)
            n = NV;
        return n;
    endfunction

    // Depth-first two-coloring from vertex 1 over the stored rows.
    function automatic t_coloring predict_coloring(int n);
        bit [31:0] live;
        bit [31:0] seen;
        bit [31:0] color;
        bit [31:0] nb;
        int        stack [NV];
        int        sp;
        int        v;
        bit        cv;
        bit        clash;
        t_coloring r;
        live  = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
        seen  = '0;
        color = '0;
        clash = 1'b0;
        sp    = 0;
        if (n > 0) begin
            seen     = 32'd1;
            color    = 32'd1;
            stack[0] = 0;
            sp       = 1;
            while (sp > 0) begin
                sp = sp - 1;
                v  = stack[sp];
                cv = color[v];
                nb = graph_rows[v] & live;
                for (int i = 0; i < n; i++) begin
                    if (nb[i]) begin
                        if (seen[i]) begin
                            if (color[i] == cv)
                                clash = 1'b1;
                        end else begin
                            seen[i] = 1'b1;
                            if (!cv)
                                color[i] = 1'b1;
                            if (sp < NV) begin
                                stack[sp] = i;
                                sp = sp + 1;
                            end
                        end
                    end
                end
            end
        end
        r.bip  = !clash;
        r.mask = clash ? 32'd0 : color;
        r.bad  = graph_bad;
        return r;
    endfunction

    task automatic accept_edge(input bit [5:0] a, input bit [5:0] b, input bit last);
        int n;
        n = effective_vertices();
        if (a == 0 || b == 0 || a > n || b > n) begin
            graph_bad = 1'b1;
        end else if (a != b) begin
            graph_rows[a-1][b-1] = 1'b1;
            graph_rows[b-1][a-1] = 1'b1;
        end
        if (last) begin
            pending_colorings.push_back(predict_coloring(n));
            foreach (graph_rows[i])
                graph_rows[i] = '0;
            graph_bad = 1'b0;
            graphs_sent++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
                 want);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_coloring want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_colorings.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = pending_colorings.pop_front();
                if (!want.bip)
                    odd_results++;
                if (m_axis_tdata[0] !== want.bip)
                    report_mismatch("is_bipartite", 40'(m_axis_tdata[0]), 40'(want.bip));
                if (m_axis_tdata[32:1] !== want.mask)
                    report_mismatch("color_mask", 40'(m_axis_tdata[32:1]), 40'(want.mask));
                if (m_axis_tdata[33] !== want.bad)
                    report_mismatch("bad_edge_seen", 40'(m_axis_tdata[33]), 40'(want.bad));
            end
        end
    end

    task automatic send_edge(input bit [5:0] a, input bit [5:0] b, input bit last);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, b, a};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        accept_edge(a, b, last);
        edges_sent++;
    endtask

    // Hold off the sender until every result is back and the last edge has settled.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_colorings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input bit [5:0] v);
        wait_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        vertex_limit = v;
        count_writes++;
    endtask

    task automatic test_default_count();
        // path 1-32-2-3 at the reset count, uses the top vertex
        send_edge(6'd1, 6'd32, 1'b0);
        send_edge(6'd32, 6'd2, 1'b0);
        send_edge(6'd2, 6'd3, 1'b1);
    endtask

    task automatic test_endpoint_extremes();
        send_edge(6'd0, 6'd5, 1'b0);
        send_edge(6'd40, 6'd1, 1'b0);
        send_edge(6'd63, 6'd63, 1'b0);
        send_edge(6'd4, 6'd4, 1'b0);
        send_edge(6'd1, 6'd2, 1'b1);
    endtask

    task automatic test_odd_cycle();
        send_edge(6'd1, 6'd2, 1'b0);
        send_edge(6'd2, 6'd3, 1'b0);
        send_edge(6'd3, 6'd1, 1'b1);
    endtask

    task automatic test_count_zero();
        write_vertex_count(6'd0);
        send_edge(6'd1, 6'd2, 1'b0);
        send_edge(6'd0, 6'd0, 1'b1);
    endtask

    task automatic test_count_one();
        write_vertex_count(6'd1);
        send_edge(6'd1, 6'd1, 1'b1);
        send_edge(6'd1, 6'd2, 1'b1);
    endtask

    task automatic test_count_above();
        write_vertex_count(6'd63);
        send_edge(6'd33, 6'd1, 1'b0);
        send_edge(6'd32, 6'd31, 1'b0);
        send_edge(6'd1, 6'd31, 1'b1);
    endtask

    task automatic test_count_lowered();
        // triangle through vertex 6, then drop the count so it is not walked
        write_vertex_count(6'd8);
        send_edge(6'd1, 6'd2, 1'b0);
        send_edge(6'd2, 6'd6, 1'b0);
        send_edge(6'd1, 6'd6, 1'b0);
        write_vertex_count(6'd5);
        send_edge(6'd2, 6'd3, 1'b1);
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int items);
        int       sent;
        int       n;
        int       k;
        int       kind;
        int       r;
        int       p;
        int       x;
        int       y;
        int       m;
        int       idx;
        int       par [NV+1];
        bit [5:0] ea [$];
        bit [5:0] eb [$];
        bit [5:0] a;
        bit [5:0] b;
        src_idle  = src_pct;
        sink_idle = sink_pct;
        sent      = 0;
        while (sent < items) begin
            if (sent == 0 || $urandom_range(99) < 25) begin
                r = $urandom_range(99);
                if (r < 70)
                    write_vertex_count(6'($urandom_range(2, 12)));
                else if (r < 85)
                    write_vertex_count(6'd32);
                else if (r < 95)
                    write_vertex_count(6'($urandom_range(13, 31)));
                else
                    write_vertex_count(6'($urandom_range(0, 63)));
            end
            n = effective_vertices();
            kind = (n < 2) ? 99 : $urandom_range(99);
            ea.delete();
            eb.delete();
            if (kind < 60) begin
                // random spanning tree plus cross edges: always two-colorable
                k = $urandom_range(2, n);
                par[1] = 0;
                for (int v = 2; v <= k; v++) begin
                    p = $urandom_range(1, v - 1);
                    par[v] = 1 - par[p];
                    ea.push_back(6'(p));
                    eb.push_back(6'(v));
                end
                m = $urandom_range(0, 4);
                for (int j = 0; j < m; j++) begin
                    x = $urandom_range(1, k);
                    y = $urandom_range(1, k);
                    if (par[x] != par[y]) begin
                        ea.push_back(6'(x));
                        eb.push_back(6'(y));
                    end
                end
                if ($urandom_range(99) < 10) begin
                    x = $urandom_range(1, n);
                    ea.push_back(6'(x));
                    eb.push_back(6'(x));
                end
                if ($urandom_range(99) < 5) begin
                    ea.push_back(6'($urandom_range(1, n)));
                    if ($urandom_range(1) != 0)
                        eb.push_back(6'd0);
                    else
                        eb.push_back(6'($urandom_range(n + 1, 63)));
                end
            end else if (kind < 85) begin
                m = $urandom_range(1, (2 * n < 24) ? 2 * n : 24);
                for (int j = 0; j < m; j++) begin
                    ea.push_back(6'($urandom_range(1, n)));
                    eb.push_back(6'($urandom_range(1, n)));
                end
            end else begin
                m = $urandom_range(1, 6);
                for (int j = 0; j < m; j++) begin
                    ea.push_back(6'($urandom_range(0, 63)));
                    eb.push_back(6'($urandom_range(0, 63)));
                end
            end
            // send in shuffled order, endpoints swapped at random
            while (ea.size() != 0) begin
                idx = $urandom_range(0, ea.size() - 1);
                a = ea[idx];
                b = eb[idx];
                ea.delete(idx);
                eb.delete(idx);
                if ($urandom_range(1) != 0)
                    send_edge(b, a, ea.size() == 0);
                else
                    send_edge(a, b, ea.size() == 0);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_count();
        test_endpoint_extremes();
        test_odd_cycle();
        test_count_zero();
        test_count_one();
        test_count_above();
        test_count_lowered();

        test_random(27, 87, 384);
        test_random(87, 27, 384);
        test_random(0, 0, 384);

        wait_quiet();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_colorings.size() != 0)
            report_mismatch("results never delivered", 40'(pending_colorings.size()), '0);

        $display("covered %0d graphs in %0d edge transfers, %0d results (%0d odd-cycle)",
                 graphs_sent, edges_sent, results_seen, odd_results);
        $display("vertex count rewritten %0d times, incl. 0, 1 and above the limit",
                 count_writes);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/bpc_pkg.sv
design/bpc_ctrl.sv
design/bpc_datapath.sv
design/bipartite_check.sv
tb/testbench.sv
